### src/pts_pkg.sv
// Shared types and constants for the periodic task tick scheduler.
package pts_pkg;

   localparam int NUM_SLOTS_DEF = 8;
   localparam logic [7:0] OVF_PER_TICK_RESET = 8'd10;

   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_CREATE  = 2'd1,
      OP_DELETE  = 2'd2,
      OP_SET_RUN = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EXEC,
      ST_FLUSH
   } state_type;

   // write strobes from the sequencer to the slot table
   typedef struct packed {
      logic create_we;
      logic run_we;
      logic cd_we;
      logic clear_valid;
   } tbl_ctl_type;

endpackage

### src/pts_table.sv
// Task slot table: valid flops plus handle, run, countdown and period memories.
module pts_table #(
   parameter int NUM_SLOTS = pts_pkg::NUM_SLOTS_DEF,
   parameter int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  pts_pkg::tbl_ctl_type tbl_ctl,
   input  logic [IDX_W-1:0]    wr_addr,
   input  logic [7:0]          wr_handle,
   input  logic                wr_running,
   input  logic [15:0]         wr_countdown,
   input  logic [15:0]         wr_period,
   input  logic [IDX_W-1:0]    rd_addr,
   output logic                rd_valid,
   output logic [7:0]          rd_handle,
   output logic                rd_running,
   output logic [15:0]         rd_countdown,
   output logic [15:0]         rd_period
);
   import pts_pkg::*;

   logic [NUM_SLOTS-1:0] valid_ff;
   logic [7:0]           handle_mem    [NUM_SLOTS];
   logic                 running_mem   [NUM_SLOTS];
   logic [15:0]          countdown_mem [NUM_SLOTS];
   logic [15:0]          period_mem    [NUM_SLOTS];

   logic                 rd_valid_ff;
   logic [7:0]           rd_handle_ff;
   logic                 rd_running_ff;
   logic [15:0]          rd_countdown_ff;
   logic [15:0]          rd_period_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (tbl_ctl.create_we) begin
         valid_ff[wr_addr] <= 1'b1;
      end else if (tbl_ctl.clear_valid) begin
         valid_ff[wr_addr] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_ctl.create_we) begin
         handle_mem[wr_addr] <= wr_handle;
         period_mem[wr_addr] <= wr_period;
      end
      if (tbl_ctl.create_we || tbl_ctl.run_we) begin
         running_mem[wr_addr] <= wr_running;
      end
      if (tbl_ctl.create_we || tbl_ctl.cd_we) begin
         countdown_mem[wr_addr] <= wr_countdown;
      end
   end

   always_ff @(posedge clock) begin
      rd_valid_ff     <= valid_ff[rd_addr];
      rd_handle_ff    <= handle_mem[rd_addr];
      rd_running_ff   <= running_mem[rd_addr];
      rd_countdown_ff <= countdown_mem[rd_addr];
      rd_period_ff    <= period_mem[rd_addr];
   end

   assign rd_valid     = rd_valid_ff;
   assign rd_handle    = rd_handle_ff;
   assign rd_running   = rd_running_ff;
   assign rd_countdown = rd_countdown_ff;
   assign rd_period    = rd_period_ff;

endmodule

### src/pts_seq.sv
// Sequencer: prescaler, table walk with the shared countdown unit, result staging.
module pts_seq #(
   parameter int NUM_SLOTS = pts_pkg::NUM_SLOTS_DEF,
   parameter int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [7:0]           csr_wdata,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_opcode,
   input  logic [2:0]           req_slot,
   input  logic [7:0]           req_task_handle,
   input  logic [15:0]          req_first_delay,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [2:0]           rsp_fired_slot,
   output logic [7:0]           rsp_fired_handle,
   output logic                 rsp_last,
   output pts_pkg::tbl_ctl_type tbl_ctl,
   output logic [IDX_W-1:0]     wr_addr,
   output logic [15:0]          wr_countdown,
   output logic [IDX_W-1:0]     rd_addr,
   input  logic                 rd_valid,
   input  logic [7:0]           rd_handle,
   input  logic                 rd_running,
   input  logic [15:0]          rd_countdown,
   input  logic [15:0]          rd_period
);
   import pts_pkg::*;

   state_type        state_ff, state_in;
   logic [7:0]       ovf_cnt_ff, ovf_cnt_in, ovf_cnt_inc;
   logic [7:0]       ovf_cfg_ff, ovf_cfg_in;
   logic [IDX_W-1:0] walk_idx_ff, walk_idx_in;
   logic             walk_del_ff, walk_del_in;
   logic [7:0]       del_handle_ff, del_handle_in;
   logic             pend_valid_ff, pend_valid_in;
   logic [2:0]       pend_slot_ff, pend_slot_in;
   logic [7:0]       pend_handle_ff, pend_handle_in;
   logic             out_valid_ff, out_valid_in;
   logic [2:0]       out_slot_ff, out_slot_in;
   logic [7:0]       out_handle_ff, out_handle_in;
   logic             out_last_ff, out_last_in;

   op_type           op;
   logic             accept;
   logic             slot_ok;
   logic             tick_hit;
   logic             walk_last;
   logic             out_free;
   logic             step_cd;
   logic             fire;
   logic             del_hit;
   logic             proceed;
   logic [15:0]      sub_opnd;
   logic [15:0]      sub_res;

   assign op          = op_type'(req_opcode);
   assign accept      = req_valid && (state_ff == ST_IDLE);
   assign ovf_cnt_inc = ovf_cnt_ff + 8'd1;
   assign tick_hit    = (ovf_cnt_inc == ovf_cfg_ff);
   assign slot_ok     = (int'(req_slot) < NUM_SLOTS);
   assign walk_last   = (walk_idx_ff == IDX_W'(NUM_SLOTS - 1));
   assign out_free    = !out_valid_ff || rsp_ready;

   assign step_cd  = (state_ff == ST_EXEC) && !walk_del_ff && rd_valid && rd_running;
   assign fire     = step_cd && (rd_countdown == 16'd0);
   assign del_hit  = (state_ff == ST_EXEC) && walk_del_ff && rd_valid
                     && (rd_handle == del_handle_ff);
   // a second firing needs room to retire the staged one
   assign proceed  = !(fire && pend_valid_ff && !out_free);

   // shared decrement: reload from period on a firing, else count down
   assign sub_opnd = fire ? rd_period : rd_countdown;
   assign sub_res  = sub_opnd - 16'd1;

   assign rd_addr  = walk_idx_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && ((op == OP_TICK && tick_hit) || op == OP_DELETE)) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (proceed) begin
               if (!walk_last) begin
                  state_in = ST_READ;
               end else if (walk_del_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff || out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // table strobes
   always_comb begin
      tbl_ctl      = '0;
      wr_addr      = walk_idx_ff;
      wr_countdown = sub_res;
      case (state_ff)
         ST_IDLE: begin
            wr_addr      = IDX_W'(req_slot);
            wr_countdown = req_first_delay;
            if (accept && slot_ok) begin
               tbl_ctl.create_we = (op == OP_CREATE);
               tbl_ctl.run_we    = (op == OP_SET_RUN);
            end
         end
         ST_EXEC: begin
            if (proceed) begin
               tbl_ctl.cd_we       = step_cd;
               tbl_ctl.clear_valid = del_hit;
            end
         end
         default: begin
         end
      endcase
   end

   // datapath registers
   always_comb begin
      ovf_cnt_in     = ovf_cnt_ff;
      ovf_cfg_in     = csr_we ? csr_wdata : ovf_cfg_ff;
      walk_idx_in    = walk_idx_ff;
      walk_del_in    = walk_del_ff;
      del_handle_in  = del_handle_ff;
      pend_valid_in  = pend_valid_ff;
      pend_slot_in   = pend_slot_ff;
      pend_handle_in = pend_handle_ff;
      out_valid_in   = out_valid_ff && !rsp_ready;
      out_slot_in    = out_slot_ff;
      out_handle_in  = out_handle_ff;
      out_last_in    = out_last_ff;

      if (accept) begin
         walk_idx_in   = '0;
         walk_del_in   = (op == OP_DELETE);
         del_handle_in = req_task_handle;
         if (op == OP_TICK) begin
            ovf_cnt_in = tick_hit ? 8'd0 : ovf_cnt_inc;
         end
      end

      if (state_ff == ST_EXEC && proceed) begin
         if (!walk_last) begin
            walk_idx_in = walk_idx_ff + IDX_W'(1);
         end
         if (fire) begin
            if (pend_valid_ff) begin
               out_valid_in  = 1'b1;
               out_slot_in   = pend_slot_ff;
               out_handle_in = pend_handle_ff;
               out_last_in   = 1'b0;
            end
            pend_valid_in  = 1'b1;
            pend_slot_in   = 3'(walk_idx_ff);
            pend_handle_in = rd_handle;
         end
      end

      // end of walk: the staged firing is the last one of this tick
      if (state_ff == ST_FLUSH && pend_valid_ff && out_free) begin
         out_valid_in  = 1'b1;
         out_slot_in   = pend_slot_ff;
         out_handle_in = pend_handle_ff;
         out_last_in   = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ovf_cnt_ff    <= 8'd0;
         ovf_cfg_ff    <= OVF_PER_TICK_RESET;
         walk_del_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ovf_cnt_ff    <= ovf_cnt_in;
         ovf_cfg_ff    <= ovf_cfg_in;
         walk_del_ff   <= walk_del_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_idx_ff    <= walk_idx_in;
      del_handle_ff  <= del_handle_in;
      pend_slot_ff   <= pend_slot_in;
      pend_handle_ff <= pend_handle_in;
      out_slot_ff    <= out_slot_in;
      out_handle_ff  <= out_handle_in;
      out_last_ff    <= out_last_in;
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = out_valid_ff;
   assign rsp_fired_slot   = out_slot_ff;
   assign rsp_fired_handle = out_handle_ff;
   assign rsp_last         = out_last_ff;

`ifndef SYNTH
   a_flush_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH) |=> (state_ff == ST_IDLE || state_ff == ST_FLUSH))
      else $error("flush state left to a walk state");

   a_no_pend_in_delete: assert property (@(posedge clock) disable iff (reset)
      (walk_del_ff && state_ff != ST_IDLE) |-> !pend_valid_ff)
      else $error("staged firing present during delete walk");

   a_flush_sets_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH && pend_valid_ff && out_free) |=> (out_valid_ff && out_last_ff))
      else $error("final firing of tick not marked last");

   a_stall_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && !proceed) |-> !(tbl_ctl.cd_we || tbl_ctl.clear_valid))
      else $error("table written while walk is stalled");
`endif

endmodule

### src/periodic_task_tick_scheduler.sv
// Top level of the periodic task tick scheduler.
//
// Input channel req_*: one transaction per command (tick, create, delete by
// handle, set run flag). Result channel rsp_*: one transaction per task that
// fires on a scheduler tick, in slot order, rsp_last high on the final one.
// csr_we/csr_wdata write the overflows-per-tick prescaler limit (reset 10).
// Create, set run flag and a tick that does not reach the prescaler limit
// leave req_ready high; the next command follows at once.
// A tick that reaches the limit, and a delete, walk the slot table one slot
// per read/update pair (states READ, EXEC) through a single memory read
// port and one shared decrement unit; a tick ends in a closing FLUSH state
// that hands the last firing to the result register. NUM_SLOTS is 8 by
// default. req_ready is low during the walk.
// The last firing is held back one step so it can be tagged with rsp_last;
// a result register decouples rsp_*. When rsp_ready is low and a firing
// needs the occupied result register, the walk (or its FLUSH state) waits
// until the result is taken.
// Reset clears all slots, the prescaler count and the pending results.
module periodic_task_tick_scheduler #(
   parameter int NUM_SLOTS = pts_pkg::NUM_SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [2:0]  req_slot,
   input  logic [7:0]  req_task_handle,
   input  logic [15:0] req_first_delay,
   input  logic [15:0] req_period,
   input  logic        req_run_flag,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_fired_slot,
   output logic [7:0]  rsp_fired_handle,
   output logic        rsp_last
);
   import pts_pkg::*;

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   tbl_ctl_type      tbl_ctl;
   logic [IDX_W-1:0] wr_addr;
   logic [IDX_W-1:0] rd_addr;
   logic [15:0]      wr_countdown;
   logic             rd_valid;
   logic [7:0]       rd_handle;
   logic             rd_running;
   logic [15:0]      rd_countdown;
   logic [15:0]      rd_period;

   pts_seq #(
      .NUM_SLOTS (NUM_SLOTS),
      .IDX_W     (IDX_W)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_slot         (req_slot),
      .req_task_handle  (req_task_handle),
      .req_first_delay  (req_first_delay),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_fired_slot   (rsp_fired_slot),
      .rsp_fired_handle (rsp_fired_handle),
      .rsp_last         (rsp_last),
      .tbl_ctl          (tbl_ctl),
      .wr_addr          (wr_addr),
      .wr_countdown     (wr_countdown),
      .rd_addr          (rd_addr),
      .rd_valid         (rd_valid),
      .rd_handle        (rd_handle),
      .rd_running       (rd_running),
      .rd_countdown     (rd_countdown),
      .rd_period        (rd_period)
   );

   pts_table #(
      .NUM_SLOTS (NUM_SLOTS),
      .IDX_W     (IDX_W)
   ) u_table (
      .clock        (clock),
      .reset        (reset),
      .tbl_ctl      (tbl_ctl),
      .wr_addr      (wr_addr),
      .wr_handle    (req_task_handle),
      .wr_running   (req_run_flag),
      .wr_countdown (wr_countdown),
      .wr_period    (req_period),
      .rd_addr      (rd_addr),
      .rd_valid     (rd_valid),
      .rd_handle    (rd_handle),
      .rd_running   (rd_running),
      .rd_countdown (rd_countdown),
      .rd_period    (rd_period)
   );

endmodule

### dv/periodic_task_tick_scheduler_tb.sv
// Self-checking testbench for the tick scheduler: directed table, then random phases.
`timescale 1ns / 100ps

module periodic_task_tick_scheduler_tb;
   import pts_pkg::*;

   localparam int NSLOT          = NUM_SLOTS_DEF;
   localparam int PREDICT        = -1;
   localparam int GAP_MAX        = 12;
   localparam int LONG_HOLD      = 300;
   localparam int DRAIN_CYCLES   = 5000;
   localparam int SETTLE_CYCLES  = 40;
   localparam int PHASE_ITEM_CAP = 1500;

   typedef struct packed {
      op_type      op;
      logic [2:0]  slot;
      logic [7:0]  handle;
      logic [15:0] delay;
      logic [15:0] period;
      logic        run;
   } cmd_type;

   typedef struct packed {
      logic [2:0] slot;
      logic [7:0] handle;
      logic       last;
   } firing_type;

   // one row of the directed table; a config row carries its value in cmd.handle
   typedef struct {
      bit         is_cfg;
      cmd_type    cmd;
      int         typed_n;
      logic [2:0] t_slot;
      logic [7:0] t_handle;
   } row_type;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        csr_we    = 1'b0;
   logic [7:0]  csr_wdata = 8'd0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_opcode      = 2'd0;
   logic [2:0]  req_slot        = 3'd0;
   logic [7:0]  req_task_handle = 8'd0;
   logic [15:0] req_first_delay = 16'd0;
   logic [15:0] req_period      = 16'd0;
   logic        req_run_flag    = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_fired_slot;
   logic [7:0]  rsp_fired_handle;
   logic        rsp_last;

   // scheduler shadow state
   bit [7:0]  ovf_limit = OVF_PER_TICK_RESET;
   bit [7:0]  ovf_count = 8'd0;
   bit        tbl_valid  [NSLOT];
   bit [7:0]  tbl_handle [NSLOT];
   bit        tbl_run    [NSLOT];
   bit [15:0] tbl_count  [NSLOT];
   bit [15:0] tbl_period [NSLOT];
   int        tick_walks = 0;

   firing_type walk_firings[$];
   firing_type pending_firings[$];
   row_type    stim_table[$];

   int mismatches       = 0;
   bit calm             = 1'b0;
   bit hold_off_pending = 1'b0;

   periodic_task_tick_scheduler u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_slot         (req_slot),
      .req_task_handle  (req_task_handle),
      .req_first_delay  (req_first_delay),
      .req_period       (req_period),
      .req_run_flag     (req_run_flag),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_fired_slot   (rsp_fired_slot),
      .rsp_fired_handle (rsp_fired_handle),
      .rsp_last         (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // advance the shadow scheduler by one command; firings land in walk_firings
   function automatic void apply_command(input cmd_type c);
      firing_type f;
      walk_firings.delete();
      case (c.op)
         OP_TICK: begin
            ovf_count = ovf_count + 8'd1;
            if (ovf_count == ovf_limit) begin
               ovf_count = 8'd0;
               tick_walks++;
               for (int i = 0; i < NSLOT; i++) begin
                  if (tbl_valid[i] && tbl_run[i]) begin
                     if (tbl_count[i] == 16'd0) begin
                        f.slot   = i[2:0];
                        f.handle = tbl_handle[i];
                        f.last   = 1'b0;
                        walk_firings.push_back(f);
                        tbl_count[i] = tbl_period[i] - 16'd1;  // period zero wraps
                     end else begin
                        tbl_count[i] = tbl_count[i] - 16'd1;
                     end
                  end
               end
               if (walk_firings.size() > 0) begin
                  f = walk_firings.pop_back();
                  f.last = 1'b1;
                  walk_firings.push_back(f);
               end
            end
         end
         OP_CREATE: begin
            tbl_valid[c.slot]  = 1'b1;
            tbl_handle[c.slot] = c.handle;
            tbl_run[c.slot]    = c.run;
            tbl_count[c.slot]  = c.delay;
            tbl_period[c.slot] = c.period;
         end
         OP_DELETE: begin
            for (int i = 0; i < NSLOT; i++) begin
               if (tbl_valid[i] && tbl_handle[i] == c.handle) tbl_valid[i] = 1'b0;
            end
         end
         OP_SET_RUN: begin
            tbl_run[c.slot] = c.run;
         end
         default: begin
         end
      endcase
   endfunction

   function automatic int draw_gap();
      if (calm || $urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, GAP_MAX);
   endfunction

   function automatic void add_row(input bit is_cfg, input op_type op, input logic [2:0] slot,
                                   input logic [7:0] handle, input logic [15:0] delay,
                                   input logic [15:0] period, input logic run,
                                   input int typed_n, input logic [2:0] t_slot,
                                   input logic [7:0] t_handle);
      row_type r;
      r.is_cfg      = is_cfg;
      r.cmd.op      = op;
      r.cmd.slot    = slot;
      r.cmd.handle  = handle;
      r.cmd.delay   = delay;
      r.cmd.period  = period;
      r.cmd.run     = run;
      r.typed_n     = typed_n;
      r.t_slot      = t_slot;
      r.t_handle    = t_handle;
      stim_table.push_back(r);
   endfunction

   // small handles and delays so deletes hit and tasks fire; full range now and then
   function automatic cmd_type random_command(input int tick_pct);
      cmd_type c;
      int      pick;
      c.slot = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 4) == 0) c.handle = 8'($urandom);
      else c.handle = 8'($urandom_range(0, 7));
      if ($urandom_range(0, 4) == 0) c.delay = 16'($urandom);
      else c.delay = 16'($urandom_range(0, 4));
      pick = int'($urandom_range(0, 9));
      if (pick == 0) c.period = 16'd0;
      else if (pick < 3) c.period = 16'($urandom);
      else c.period = 16'($urandom_range(1, 5));
      c.run = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 99) < tick_pct) begin
         c.op = OP_TICK;
      end else begin
         pick = int'($urandom_range(0, 19));
         if (pick < 12) c.op = OP_CREATE;
         else if (pick < 17) c.op = OP_SET_RUN;
         else c.op = OP_DELETE;
      end
      return c;
   endfunction

   task automatic send_cmd(input cmd_type c, input int typed_n, input logic [2:0] t_slot,
                           input logic [7:0] t_handle);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= c.op;
      req_slot        <= c.slot;
      req_task_handle <= c.handle;
      req_first_delay <= c.delay;
      req_period      <= c.period;
      req_run_flag    <= c.run;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      apply_command(c);
      if (typed_n == PREDICT) begin
         foreach (walk_firings[k]) pending_firings.push_back(walk_firings[k]);
      end else if (typed_n == 1) begin
         pending_firings.push_back(firing_type'{slot: t_slot, handle: t_handle, last: 1'b1});
      end
   endtask

   task automatic write_limit(input logic [7:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      ovf_limit = value;
   endtask

   // block is idle once every firing is out and the settle wait (SETTLE_CYCLES) has passed
   task automatic wait_drained();
      int w;
      for (w = 0; w < DRAIN_CYCLES && pending_firings.size() != 0; w++) @(posedge clock);
      if (pending_firings.size() != 0) begin
         $error("%0d expected firings never arrived", pending_firings.size());
         mismatches++;
         pending_firings.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input logic [7:0] limit, input int min_items, input int tick_pct,
                            input bit need_walk, input bit quiet, input bit stall_rsp);
      int      sent;
      int      walks_start;
      int      walk_at;
      cmd_type c;
      wait_drained();
      write_limit(limit);
      calm             = quiet;
      hold_off_pending = stall_rsp;
      sent             = 0;
      walks_start      = tick_walks;
      walk_at          = 0;
      // slow prescaler settings run until a walk happened, plus a tail past it
      while (sent < PHASE_ITEM_CAP &&
             (sent < min_items ||
              (need_walk && (tick_walks == walks_start || sent - walk_at < 15)))) begin
         c = random_command(tick_pct);
         send_cmd(c, PREDICT, 3'd0, 8'd0);
         sent++;
         if (tick_walks != walks_start && walk_at == 0) walk_at = sent;
      end
      req_valid <= 1'b0;
      calm = 1'b0;
   endtask

   initial begin : stimulus
      row_type    r;
      logic [7:0] mid_limit;

      // reset value of the prescaler: ten overflows per walk
      add_row(1'b0, OP_CREATE, 3'd0, 8'hA5, 16'd0, 16'd0, 1'b1, 0, 3'd0, 8'h00);
      repeat (9) add_row(1'b0, OP_TICK, 3'd0, 8'h00, 16'd0, 16'd0, 1'b0, 0, 3'd0, 8'h00);
      add_row(1'b0, OP_TICK, 3'd0, 8'h00, 16'd0, 16'd0, 1'b0, 1, 3'd0, 8'hA5);
      // config row: every overflow is a tick from here on
      add_row(1'b1, OP_TICK, 3'd0, 8'd1, 16'd0, 16'd0, 1'b0, 0, 3'd0, 8'h00);
      add_row(1'b0, OP_CREATE, 3'd7, 8'hFF, 16'd0, 16'd1, 1'b1, 0, 3'd0, 8'h00);
      add_row(1'b0, OP_CREATE, 3'd3, 8'h00, 16'hFFFF, 16'hFFFF, 1'b1, 0, 3'd0, 8'h00);
      add_row(1'b0, OP_CREATE, 3'd5, 8'h5A, 16'd1, 16'd0, 1'b0, 0, 3'd0, 8'h00);
      add_row(1'b0, OP_TICK, 3'd0, 8'h00, 16'd0, 16'd0, 1'b0, 1, 3'd7, 8'hFF);
      add_row(1'b0, OP_TICK, 3'd0, 8'h00, 16'd0, 16'd0, 1'b0, 1, 3'd7, 8'hFF);
      add_row(1'b0, OP_SET_RUN, 3'd5, 8'h00, 16'd0, 16'd0, 1'b1, 0, 3'd0, 8'h00);
      add_row(1'b0, OP_TICK, 3'd0, 8'h00, 16'd0, 16'd0, 1'b0, 1, 3'd7, 8'hFF);
      add_row(1'b0, OP_TICK, 3'd0, 8'h00, 16'd0, 16'd0, 1'b0, PREDICT, 3'd0, 8'h00);
      // run flag on an empty slot, later overwritten by create
      add_row(1'b0, OP_SET_RUN, 3'd2, 8'h00, 16'd0, 16'd0, 1'b1, 0, 3'd0, 8'h00);
      add_row(1'b0, OP_TICK, 3'd0, 8'h00, 16'd0, 16'd0, 1'b0, PREDICT, 3'd0, 8'h00);
      add_row(1'b0, OP_CREATE, 3'd7, 8'h5A, 16'd2, 16'd3, 1'b1, 0, 3'd0, 8'h00);
      add_row(1'b0, OP_DELETE, 3'd0, 8'h5A, 16'd0, 16'd0, 1'b0, 0, 3'd0, 8'h00);
      add_row(1'b0, OP_DELETE, 3'd0, 8'h33, 16'd0, 16'd0, 1'b0, 0, 3'd0, 8'h00);
      add_row(1'b0, OP_TICK, 3'd0, 8'h00, 16'd0, 16'd0, 1'b0, 0, 3'd0, 8'h00);
      add_row(1'b0, OP_CREATE, 3'd2, 8'h11, 16'd0, 16'd2, 1'b0, 0, 3'd0, 8'h00);
      add_row(1'b0, OP_TICK, 3'd0, 8'h00, 16'd0, 16'd0, 1'b0, 0, 3'd0, 8'h00);
      add_row(1'b0, OP_SET_RUN, 3'd2, 8'h00, 16'd0, 16'd0, 1'b1, 0, 3'd0, 8'h00);
      add_row(1'b0, OP_TICK, 3'd0, 8'h00, 16'd0, 16'd0, 1'b0, PREDICT, 3'd0, 8'h00);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_table[i]) begin
         r = stim_table[i];
         if (r.is_cfg) begin
            req_valid <= 1'b0;
            wait_drained();
            write_limit(r.cmd.handle);
         end else begin
            send_cmd(r.cmd, r.typed_n, r.t_slot, r.t_handle);
         end
      end
      req_valid <= 1'b0;

      mid_limit = 8'($urandom_range(2, 12));
      run_phase(8'd1, 70, 45, 1'b0, 1'b0, 1'b1);    // long result stall fills the block
      run_phase(8'd3, 60, 60, 1'b0, 1'b1, 1'b0);    // back to back, no idling
      run_phase(8'd255, 200, 97, 1'b0, 1'b0, 1'b0); // count climbs, limit not reached
      run_phase(8'd0, 20, 97, 1'b1, 1'b0, 1'b0);    // below current count: wraps at 256
      run_phase(mid_limit, 40, 60, 1'b0, 1'b0, 1'b0);

      wait_drained();
      if (mismatches == 0) begin
         $display("periodic_task_tick_scheduler verification clean");
      end else begin
         $display("periodic_task_tick_scheduler verification failed");
      end
      $finish;
   end

   initial begin : rsp_side
      firing_type want;
      int         gap;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         gap = draw_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         // transaction taken at this edge
         if (pending_firings.size() == 0) begin
            $error("unexpected firing: slot %0d handle 0x%0h last %0b",
                   rsp_fired_slot, rsp_fired_handle, rsp_last);
            mismatches++;
         end else begin
            want = pending_firings.pop_front();
            if (rsp_fired_slot !== want.slot) begin
               $error("fired_slot: expected %0d, got %0d", want.slot, rsp_fired_slot);
               mismatches++;
            end
            if (rsp_fired_handle !== want.handle) begin
               $error("fired_handle: expected 0x%0h, got 0x%0h", want.handle, rsp_fired_handle);
               mismatches++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_last);
               mismatches++;
            end
         end
      end
   end

   initial begin : watchdog
      #5_000_000;
      $display("periodic_task_tick_scheduler verification failed");
      $finish;
   end

endmodule
